### hw/rtl/sgf_pkg.sv
package sgf_pkg;

  localparam int SCAN_POINTS_DEF = 1024;
  localparam int DATA_W          = 16;
  localparam int INDEX_OUT_W     = 10;
  localparam int KIND_W          = 2;
  localparam int PT_W            = 3 * DATA_W;

  localparam logic [DATA_W-1:0] ROBOT_WIDTH_RST = 16'd600;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAP  = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT,
    DP_GSTART,
    DP_READ,
    DP_INC,
    DP_R0_INC,
    DP_OPEN_RIGHT,
    DP_ER_INC,
    DP_ER_EL,
    DP_SET_EL,
    DP_BREF,
    DP_FREF,
    DP_REFD,
    DP_WSTEP,
    DP_WABS,
    DP_SQX,
    DP_SQY,
    DP_WBEST,
    DP_REJECT,
    DP_SAVE_P1,
    DP_PASS,
    DP_OUT_OPEN,
    DP_OUT_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic start_ge_n;
    logic i_at_end;
    logic walk_end;
    logic fwd;
    logic first;
    logic found;
    logic r_neg;
    logic r_pos;
    logic jump;
    logic better;
    logic close;
  } dp_stat_t;

endpackage

### hw/rtl/sgf_ctrl.sv
module sgf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_point,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sgf_pkg::dp_stat_t st,
  output sgf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_GSTART, S_GFIRST, S_SKIP1, S_SKIP1D, S_RUN, S_RUND,
    S_SKIP2, S_SKIP2D, S_BREF, S_FREF, S_REFD, S_WTEST, S_WRD, S_SQX, S_SQY,
    S_CMP, S_REJ, S_STEP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   open_r, open_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = sgf_pkg::DP_NOP;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.op = sgf_pkg::DP_LOAD;
          if (in_last_point) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op    = sgf_pkg::DP_INIT;
        open_nxt  = 1'b0;
        state_nxt = S_GSTART;
      end
      S_GSTART: begin
        if (st.start_ge_n) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = sgf_pkg::DP_GSTART;
          state_nxt = S_GFIRST;
        end
      end
      S_GFIRST: begin
        if (st.r_neg) begin
          cmd.op    = sgf_pkg::DP_INC;
          state_nxt = S_SKIP1;
        end else begin
          cmd.op    = sgf_pkg::DP_R0_INC;
          state_nxt = S_RUN;
        end
      end
      S_SKIP1: begin
        if (st.i_at_end) begin
          open_nxt  = st.first;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = sgf_pkg::DP_READ;
          state_nxt = S_SKIP1D;
        end
      end
      S_SKIP1D: begin
        if (st.r_neg) begin
          cmd.op    = sgf_pkg::DP_INC;
          state_nxt = S_SKIP1;
        end else begin
          cmd.op    = sgf_pkg::DP_OPEN_RIGHT;
          state_nxt = S_GSTART;
        end
      end
      S_RUN: begin
        if (st.i_at_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = sgf_pkg::DP_READ;
          state_nxt = S_RUND;
        end
      end
      S_RUND: begin
        if (st.r_neg) begin
          cmd.op    = sgf_pkg::DP_ER_INC;
          state_nxt = S_SKIP2;
        end else if (st.jump) begin
          cmd.op    = sgf_pkg::DP_ER_EL;
          state_nxt = S_BREF;
        end else begin
          cmd.op    = sgf_pkg::DP_R0_INC;
          state_nxt = S_RUN;
        end
      end
      S_SKIP2: begin
        if (st.i_at_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = sgf_pkg::DP_READ;
          state_nxt = S_SKIP2D;
        end
      end
      S_SKIP2D: begin
        if (st.r_neg) begin
          cmd.op    = sgf_pkg::DP_INC;
          state_nxt = S_SKIP2;
        end else begin
          cmd.op    = sgf_pkg::DP_SET_EL;
          state_nxt = S_BREF;
        end
      end
      S_BREF: begin
        cmd.op    = sgf_pkg::DP_BREF;
        state_nxt = S_REFD;
      end
      S_FREF: begin
        cmd.op    = sgf_pkg::DP_FREF;
        state_nxt = S_REFD;
      end
      S_REFD: begin
        cmd.op    = sgf_pkg::DP_REFD;
        state_nxt = S_WTEST;
      end
      S_WTEST: begin
        if (st.walk_end) begin
          if (!st.found) begin
            cmd.op    = sgf_pkg::DP_REJECT;
            state_nxt = S_GSTART;
          end else if (!st.fwd) begin
            cmd.op    = sgf_pkg::DP_SAVE_P1;
            state_nxt = S_FREF;
          end else begin
            cmd.op    = sgf_pkg::DP_PASS;
            state_nxt = S_GSTART;
          end
        end else begin
          cmd.op    = sgf_pkg::DP_READ;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        if (st.r_pos) begin
          cmd.op    = sgf_pkg::DP_WABS;
          state_nxt = S_SQX;
        end else begin
          cmd.op    = sgf_pkg::DP_WSTEP;
          state_nxt = S_WTEST;
        end
      end
      S_SQX: begin
        cmd.op    = sgf_pkg::DP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = sgf_pkg::DP_SQY;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (st.better) begin
          cmd.op    = sgf_pkg::DP_WBEST;
          state_nxt = st.close ? S_REJ : S_STEP;
        end else begin
          cmd.op    = sgf_pkg::DP_WSTEP;
          state_nxt = S_WTEST;
        end
      end
      S_REJ: begin
        cmd.op    = sgf_pkg::DP_REJECT;
        state_nxt = S_GSTART;
      end
      S_STEP: begin
        cmd.op    = sgf_pkg::DP_WSTEP;
        state_nxt = S_WTEST;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = open_r ? sgf_pkg::DP_OUT_OPEN : sgf_pkg::DP_OUT_DONE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      open_r      <= open_nxt;
    end
  end

endmodule

### hw/rtl/sgf_dp.sv
module sgf_dp #(
  parameter int SCAN_POINTS = sgf_pkg::SCAN_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic        [sgf_pkg::DATA_W-1:0]   cfg_wdata,
  input  logic signed [sgf_pkg::DATA_W-1:0]   in_range_mm,
  input  logic signed [sgf_pkg::DATA_W-1:0]   in_x_mm,
  input  logic signed [sgf_pkg::DATA_W-1:0]   in_y_mm,
  input  sgf_pkg::dp_cmd_t                    cmd,
  output sgf_pkg::dp_stat_t                   st,
  output logic [sgf_pkg::KIND_W-1:0]          out_gap_kind,
  output logic [sgf_pkg::INDEX_OUT_W-1:0]     out_right_index,
  output logic [sgf_pkg::INDEX_OUT_W-1:0]     out_left_index
);

  localparam int IW = (SCAN_POINTS > 1) ? $clog2(SCAN_POINTS) : 1;
  localparam int CW = $clog2(SCAN_POINTS + 1);
  localparam int DW = sgf_pkg::DATA_W;

  logic [sgf_pkg::PT_W-1:0] mem [SCAN_POINTS];
  logic [sgf_pkg::PT_W-1:0] rd_r;
  logic [IW-1:0]            raddr;

  logic [DW-1:0]        w_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        i_r, start_r, er_r, el_r, p1_r, bidx_r;
  logic [CW-1:0]        h1_r, h2_r;
  logic signed [DW-1:0] r0_r, ref_x_r, ref_y_r, cur_y_r, best_y_r;
  logic [DW-1:0]        adx_r, ady_r;
  logic [2*DW-1:0]      wsq_r, sqx_r, sqy_r;
  logic [2*DW:0]        bestd_r;
  logic [DW:0]          best_abs_r;
  logic                 first_r, found_r, have_r, fwd_r;
  logic [sgf_pkg::KIND_W-1:0]      kind_r;
  logic [sgf_pkg::INDEX_OUT_W-1:0] ridx_r, lidx_r;

  logic signed [DW-1:0] rng, px, py;
  logic signed [DW:0]   rdiff, dx, dy, ysum;
  logic [DW:0]          rabs, dxa, dya, yabs;
  logic [2*DW:0]        dsum;
  logic [DW-1:0]        mul_a;
  logic [2*DW-1:0]      prod;
  logic                 abs_better;

  function automatic logic [DW:0] abs17(input logic signed [DW:0] v);
    abs17 = v[DW] ? (DW+1)'(-v) : (DW+1)'(v);
  endfunction

  assign rng   = rd_r[3*DW-1:2*DW];
  assign px    = rd_r[2*DW-1:DW];
  assign py    = rd_r[DW-1:0];
  assign rdiff = {rng[DW-1], rng} - {r0_r[DW-1], r0_r};
  assign rabs  = abs17(rdiff);
  assign dx    = {px[DW-1], px} - {ref_x_r[DW-1], ref_x_r};
  assign dy    = {py[DW-1], py} - {ref_y_r[DW-1], ref_y_r};
  assign dxa   = abs17(dx);
  assign dya   = abs17(dy);
  assign dsum  = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign ysum  = {ref_y_r[DW-1], ref_y_r} + {best_y_r[DW-1], best_y_r};
  assign yabs  = abs17(ysum);
  assign abs_better = !have_r || (yabs < best_abs_r);

  always_comb begin
    unique case (cmd.op)
      sgf_pkg::DP_SQX: mul_a = adx_r;
      sgf_pkg::DP_SQY: mul_a = ady_r;
      default:         mul_a = w_r;
    endcase
  end
  assign prod = mul_a * mul_a;

  always_comb begin
    unique case (cmd.op)
      sgf_pkg::DP_GSTART: raddr = start_r[IW-1:0];
      sgf_pkg::DP_BREF:   raddr = el_r[IW-1:0];
      sgf_pkg::DP_FREF:   raddr = p1_r[IW-1:0];
      default:            raddr = i_r[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sgf_pkg::DP_LOAD && count_r < CW'(SCAN_POINTS)) begin
      mem[count_r[IW-1:0]] <= {in_range_mm, in_x_mm, in_y_mm};
    end
    rd_r <= mem[raddr];
  end

  always_comb begin
    st.start_ge_n = (start_r >= count_r);
    st.i_at_end   = (i_r == count_r);
    st.fwd        = fwd_r;
    st.walk_end   = fwd_r ? (i_r == count_r) : (i_r == '0);
    st.first      = first_r;
    st.found      = found_r;
    st.r_neg      = rng[DW-1];
    st.r_pos      = !rng[DW-1] && (rng != '0);
    st.jump       = (rabs >= {1'b0, w_r});
    st.better     = !found_r || (dsum < bestd_r);
    st.close      = (dsum < {1'b0, wsq_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= sgf_pkg::ROBOT_WIDTH_RST;
      count_r <= '0;
    end else begin
      if (cfg_we) w_r <= cfg_wdata;
      if (cmd.op == sgf_pkg::DP_LOAD && count_r < CW'(SCAN_POINTS)) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.op == sgf_pkg::DP_OUT_OPEN || cmd.op == sgf_pkg::DP_OUT_DONE) begin
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sgf_pkg::DP_INIT: begin
        wsq_r   <= prod;
        start_r <= '0;
        have_r  <= 1'b0;
        first_r <= 1'b1;
      end
      sgf_pkg::DP_GSTART: i_r <= start_r;
      sgf_pkg::DP_INC:    i_r <= i_r + 1'b1;
      sgf_pkg::DP_R0_INC: begin
        r0_r <= rng;
        i_r  <= i_r + 1'b1;
      end
      sgf_pkg::DP_OPEN_RIGHT: begin
        el_r    <= i_r;
        start_r <= i_r;
        first_r <= 1'b0;
      end
      sgf_pkg::DP_ER_INC: begin
        er_r <= i_r - 1'b1;
        i_r  <= i_r + 1'b1;
      end
      sgf_pkg::DP_ER_EL: begin
        er_r    <= i_r - 1'b1;
        el_r    <= i_r;
        first_r <= 1'b0;
      end
      sgf_pkg::DP_SET_EL: begin
        el_r    <= i_r;
        first_r <= 1'b0;
      end
      sgf_pkg::DP_BREF: fwd_r <= 1'b0;
      sgf_pkg::DP_FREF: fwd_r <= 1'b1;
      sgf_pkg::DP_REFD: begin
        ref_x_r <= px;
        ref_y_r <= py;
        i_r     <= fwd_r ? el_r : er_r;
        found_r <= 1'b0;
      end
      sgf_pkg::DP_WSTEP: i_r <= fwd_r ? i_r + 1'b1 : i_r - 1'b1;
      sgf_pkg::DP_WABS: begin
        adx_r   <= dxa[DW-1:0];
        ady_r   <= dya[DW-1:0];
        cur_y_r <= py;
      end
      sgf_pkg::DP_SQX: sqx_r <= prod;
      sgf_pkg::DP_SQY: sqy_r <= prod;
      sgf_pkg::DP_WBEST: begin
        bestd_r  <= dsum;
        bidx_r   <= i_r;
        best_y_r <= cur_y_r;
        found_r  <= 1'b1;
      end
      sgf_pkg::DP_REJECT:  start_r <= el_r;
      sgf_pkg::DP_SAVE_P1: p1_r    <= bidx_r;
      sgf_pkg::DP_PASS: begin
        start_r <= bidx_r;
        if (abs_better) begin
          best_abs_r <= yabs;
          h1_r       <= p1_r;
          h2_r       <= bidx_r;
          have_r     <= 1'b1;
        end
      end
      sgf_pkg::DP_OUT_OPEN: begin
        kind_r <= sgf_pkg::KIND_OPEN;
        ridx_r <= '0;
        lidx_r <= '0;
      end
      sgf_pkg::DP_OUT_DONE: begin
        kind_r <= have_r ? sgf_pkg::KIND_GAP : sgf_pkg::KIND_NONE;
        ridx_r <= have_r ? sgf_pkg::INDEX_OUT_W'(h1_r) : '0;
        lidx_r <= have_r ? sgf_pkg::INDEX_OUT_W'(h2_r) : '0;
      end
      default: ;
    endcase
  end

  assign out_gap_kind    = kind_r;
  assign out_right_index = ridx_r;
  assign out_left_index  = lidx_r;

endmodule

### hw/rtl/scan_gap_finder_core.sv
// Channel  Ports                                          Beat
// in       in_valid/in_ready, range/x/y/last_point        one scan point
// out      out_valid/out_ready, gap_kind/right/left index one search result
// cfg      cfg_we, cfg_wdata                              robot width write
//
// Points load one per cycle into a one-write, one-read store; a beat with
// in_last_point starts the search, during which in_ready is low.
// The gap scan reads each point, then tests its range; a distance walk reads
// each point and squares and compares its offsets only when it has a return.
// A finished result waits in the output register; rst_n is synchronous.
module scan_gap_finder_core #(
  parameter int SCAN_POINTS = sgf_pkg::SCAN_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic        [sgf_pkg::DATA_W-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sgf_pkg::DATA_W-1:0]   in_range_mm,
  input  logic signed [sgf_pkg::DATA_W-1:0]   in_x_mm,
  input  logic signed [sgf_pkg::DATA_W-1:0]   in_y_mm,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sgf_pkg::KIND_W-1:0]          out_gap_kind,
  output logic [sgf_pkg::INDEX_OUT_W-1:0]     out_right_index,
  output logic [sgf_pkg::INDEX_OUT_W-1:0]     out_left_index
);

  sgf_pkg::dp_cmd_t  cmd;
  sgf_pkg::dp_stat_t st;

  sgf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .st            (st),
    .cmd           (cmd)
  );

  sgf_dp #(
    .SCAN_POINTS (SCAN_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_range_mm     (in_range_mm),
    .in_x_mm         (in_x_mm),
    .in_y_mm         (in_y_mm),
    .cmd             (cmd),
    .st              (st),
    .out_gap_kind    (out_gap_kind),
    .out_right_index (out_right_index),
    .out_left_index  (out_left_index)
  );

endmodule

### tb/scan_gap_finder_core_tb.sv
`timescale 1ns / 1ps

module scan_gap_finder_core_tb;

  localparam int STORE_DEPTH = sgf_pkg::SCAN_POINTS_DEF;
  localparam int STALL_LIMIT = 16000000;
  localparam int LONG_HOLD   = 600;

  typedef enum int {CAND_NONE, CAND_ALL_INVALID, CAND_OPEN_RIGHT, CAND_OPEN_LEFT,
                    CAND_BOUNDED} cand_t;

  typedef enum int {SHAPE_SMOOTH, SHAPE_NOISE, SHAPE_CLUSTER} shape_t;

  typedef struct {
    logic signed [sgf_pkg::DATA_W-1:0] r;
    logic signed [sgf_pkg::DATA_W-1:0] x;
    logic signed [sgf_pkg::DATA_W-1:0] y;
    logic                              last;
  } point_t;

  typedef struct {
    logic [sgf_pkg::KIND_W-1:0]      kind;
    logic [sgf_pkg::INDEX_OUT_W-1:0] right;
    logic [sgf_pkg::INDEX_OUT_W-1:0] left;
  } gap_t;

  logic clk, rst_n, cfg_we;
  logic [sgf_pkg::DATA_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_last_point, out_valid, out_ready;
  logic signed [sgf_pkg::DATA_W-1:0] in_range_mm, in_x_mm, in_y_mm;
  logic [sgf_pkg::KIND_W-1:0] out_gap_kind;
  logic [sgf_pkg::INDEX_OUT_W-1:0] out_right_index, out_left_index;

  scan_gap_finder_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_range_mm(in_range_mm),
    .in_x_mm(in_x_mm), .in_y_mm(in_y_mm), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready), .out_gap_kind(out_gap_kind),
    .out_right_index(out_right_index), .out_left_index(out_left_index)
  );

  point_t pend_points[$];
  gap_t   gap_expected[$];
  int     errors = 0;
  int     items_queued = 0;
  bit     in_acc = 0, out_acc = 0, idle_on = 0, hold_req = 0;
  int     send_gap = 0, rcv_stall = 0, hold_left = 0, quiet_cycles = 0;

  int range_st[STORE_DEPTH];
  int x_st[STORE_DEPTH];
  int y_st[STORE_DEPTH];
  int unsigned pts_stored = 0;
  int unsigned width_mm = sgf_pkg::ROBOT_WIDTH_RST;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic cand_t find_gap(input int unsigned s, input int unsigned n,
                                     output int unsigned er, output int unsigned el);
    int unsigned i;
    int r, r0, d;
    er = 0;
    el = 0;
    i = s;
    if (i >= n) return CAND_NONE;
    r = range_st[i];
    if (r < 0) begin
      i++;
      while (i < n && range_st[i] < 0) i++;
      if (i == n) return CAND_ALL_INVALID;
      el = i;
      return CAND_OPEN_RIGHT;
    end
    r0 = r;
    i++;
    while (i < n) begin
      r = range_st[i];
      if (r < 0) break;
      d = (r > r0) ? r - r0 : r0 - r;
      if (d >= int'(width_mm)) break;
      r0 = r;
      i++;
    end
    if (i == n) return CAND_NONE;
    er = i - 1;
    if (r < 0) begin
      i++;
      while (i < n && range_st[i] < 0) i++;
      if (i == n) return CAND_OPEN_LEFT;
    end
    el = i;
    return CAND_BOUNDED;
  endfunction

  function automatic bit clear_walk(input int unsigned from, input int unsigned refp,
                                    input int unsigned n, input bit fwd,
                                    output int unsigned best, output bit found);
    longint unsigned wsq, bestd, d;
    longint dx, dy;
    int unsigned i;
    wsq = longint'(width_mm) * longint'(width_mm);
    bestd = 0;
    best = 0;
    found = 0;
    i = from;
    while (fwd ? (i < n) : (i > 0)) begin
      if (range_st[i] > 0) begin
        dx = longint'(x_st[i]) - longint'(x_st[refp]);
        dy = longint'(y_st[i]) - longint'(y_st[refp]);
        d = dx * dx + dy * dy;
        if (!found || d < bestd) begin
          bestd = d;
          best = i;
          found = 1;
          if (d < wsq) return 0;
        end
      end
      if (fwd) i++;
      else i--;
    end
    return 1;
  endfunction

  function automatic gap_t search_scan();
    gap_t res;
    int unsigned n, start, er, el, p1, p2, h1, h2, a, best_abs;
    bit f1, f2, ok, have;
    cand_t c;
    int s;
    n = pts_stored;
    start = 0;
    h1 = 0;
    h2 = 0;
    best_abs = 0;
    have = 0;
    res.kind = sgf_pkg::KIND_NONE;
    c = find_gap(0, n, er, el);
    if (c == CAND_ALL_INVALID) begin
      res.kind = sgf_pkg::KIND_OPEN;
    end else if (c != CAND_NONE) begin
      forever begin
        c = find_gap(start, n, er, el);
        if (c != CAND_OPEN_RIGHT && c != CAND_BOUNDED) break;
        if (c == CAND_OPEN_RIGHT) begin
          start = el;
          continue;
        end
        p1 = 0;
        p2 = 0;
        ok = clear_walk(er, el, n, 0, p1, f1) && f1;
        if (ok) ok = clear_walk(el, p1, n, 1, p2, f2) && f2;
        if (ok) begin
          s = y_st[p1] + y_st[p2];
          a = (s < 0) ? -s : s;
          if (!have || a < best_abs) begin
            best_abs = a;
            h1 = p1;
            h2 = p2;
            have = 1;
          end
          start = p2;
        end else begin
          start = el;
        end
      end
      if (have) res.kind = sgf_pkg::KIND_GAP;
    end
    res.right = have ? h1[sgf_pkg::INDEX_OUT_W-1:0] : '0;
    res.left  = have ? h2[sgf_pkg::INDEX_OUT_W-1:0] : '0;
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    gap_t want;
    in_acc = rst_n && in_valid && in_ready;
    out_acc = rst_n && out_valid && out_ready;
    if (in_acc) begin
      if (pts_stored < STORE_DEPTH) begin
        range_st[pts_stored] = int'(in_range_mm);
        x_st[pts_stored] = int'(in_x_mm);
        y_st[pts_stored] = int'(in_y_mm);
        pts_stored++;
      end
      if (in_last_point) begin
        gap_expected.push_back(search_scan());
        pts_stored = 0;
      end
    end
    if (out_acc) begin
      if (gap_expected.size() == 0) begin
        report("unexpected result kind", out_gap_kind, -1);
      end else begin
        want = gap_expected.pop_front();
        if (out_gap_kind !== want.kind) report("gap_kind", out_gap_kind, want.kind);
        if (out_right_index !== want.right)
          report("right_index", out_right_index, want.right);
        if (out_left_index !== want.left)
          report("left_index", out_left_index, want.left);
      end
    end
    if (in_acc || out_acc) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_acc) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (pend_points.size() > 0) begin
        p = pend_points.pop_front();
        in_range_mm <= p.r;
        in_x_mm <= p.x;
        in_y_mm <= p.y;
        in_last_point <= p.last;
        in_valid <= 1;
        send_gap = idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_acc) rcv_stall = idle_on ? $urandom_range(0, 10) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = LONG_HOLD;
        out_ready <= 0;
      end else if (rcv_stall > 0) begin
        rcv_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic add_pt(input int r, input int x, input int y, input bit last);
    point_t p;
    p.r = r;
    p.x = x;
    p.y = y;
    p.last = last;
    pend_points.push_back(p);
    items_queued++;
  endtask

  task automatic add_scan(input int len, input shape_t shape);
    int base, r, x, y, u;
    base = $urandom_range(200, 8000);
    for (int i = 0; i < len; i++) begin
      u = $urandom_range(0, 99);
      if (shape == SHAPE_NOISE) begin
        r = $urandom;
        x = $urandom;
        y = $urandom;
      end else begin
        if (u < 10) begin
          r = -$urandom_range(1, 32768);
        end else begin
          if (u < 22) base = $urandom_range(0, 32767);
          else base += $urandom_range(0, 400) - 200;
          if (base < 0) base = 0;
          if (base > 32767) base = 32767;
          r = (u < 25) ? 0 : base;
        end
        if (shape == SHAPE_CLUSTER) begin
          x = $urandom_range(0, 3000) - 1500;
          y = $urandom_range(0, 3000) - 1500;
        end else begin
          x = $urandom;
          y = $urandom;
        end
      end
      add_pt(r, x, y, i == len - 1);
    end
  endtask

  task automatic write_width(input int unsigned v);
    @(negedge clk);
    cfg_wdata <= v[sgf_pkg::DATA_W-1:0];
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    width_mm = v & 16'hFFFF;
  endtask

  task automatic drain();
    while (pend_points.size() > 0 || in_valid) @(posedge clk);
    while (gap_expected.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int unsigned widths[6];
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_range_mm = 0;
    in_x_mm = 0;
    in_y_mm = 0;
    in_last_point = 0;
    out_ready = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    add_pt(-32768, 32767, -32768, 1);
    add_pt(-1, 0, 0, 0);
    add_pt(-5, 100, 100, 1);
    add_pt(1000, -30000, 0, 0);
    add_pt(1010, -30000, 5000, 0);
    add_pt(1020, 30000, 5000, 1);
    add_pt(1000, -32768, -32768, 0);
    add_pt(1000, -20000, -20000, 0);
    add_pt(-1, 0, 0, 0);
    add_pt(3000, 20000, 20000, 0);
    add_pt(3000, 32767, 32767, 1);
    add_pt(-1, 0, 0, 0);
    add_pt(500, 10000, 0, 0);
    add_pt(510, 20000, 0, 1);
    add_pt(32767, 0, 0, 0);
    add_pt(0, 100, 0, 0);
    add_pt(-1, 0, 0, 0);
    add_pt(32767, -200, 0, 1);
    drain();

    write_width(65535);
    add_pt(100, 0, 0, 0);
    add_pt(-1, 0, 0, 0);
    add_pt(100, 30000, 0, 1);
    drain();

    write_width(0);
    for (int i = 0; i < 1030; i++) add_pt(100, $urandom, $urandom, i == 1029);
    drain();

    widths[0] = 600;
    widths[1] = 0;
    widths[2] = 65535;
    widths[3] = 1;
    widths[4] = $urandom_range(0, 65535);
    widths[5] = $urandom_range(100, 3000);
    for (int ph = 0; items_queued < 1900; ph++) begin
      write_width(widths[ph % 6]);
      idle_on = (ph % 3) != 0;
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < 300; ) begin
        int len, sel;
        len = $urandom_range(1, 24);
        sel = $urandom_range(0, 9);
        add_scan(len, sel < 6 ? SHAPE_SMOOTH : (sel < 8 ? SHAPE_CLUSTER : SHAPE_NOISE));
        k += len;
      end
      drain();
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/sgf_pkg.sv
hw/rtl/sgf_ctrl.sv
hw/rtl/sgf_dp.sv
hw/rtl/scan_gap_finder_core.sv
tb/scan_gap_finder_core_tb.sv
